/* src/tpe_pkg.sv */
// Package of shared types, codes and helpers for the timer pool with expiry.
`timescale 1ns / 1ps
package tpe_pkg;

   localparam int DUR_W   = 31;
   localparam int PER_W   = 16;
   localparam int SIG_W   = 8;
   localparam int SLOT_W  = 3;
   localparam int VAL_W   = 32;
   localparam int PROD_W  = VAL_W + PER_W + 1;

   localparam logic [DUR_W-1:0] ELAPSED_MAX = {DUR_W{1'b1}};

   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_ALLOC  = 3'd1;
   localparam logic [2:0] ACT_FREE   = 3'd2;
   localparam logic [2:0] ACT_READ   = 3'd3;
   localparam logic [2:0] ACT_RESET  = 3'd4;
   localparam logic [2:0] ACT_TTE    = 3'd5;
   localparam logic [2:0] ACT_COUNT  = 3'd6;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EXPIRY = 2'd2;

   typedef struct packed {
      logic [2:0]       action;
      logic [DUR_W-1:0] duration_ms;
      logic             has_signal;
      logic [SIG_W-1:0] signal_id;
      logic [SLOT_W-1:0] slot_id;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [SLOT_W-1:0]       slot_out;
      logic signed [VAL_W-1:0] value_ms;
      logic [SIG_W-1:0]        signal_out;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [SIG_W-1:0] sig;
      logic [DUR_W-1:0] target;
      logic [DUR_W-1:0] elapsed;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   // Clamps a wide signed product to the signed 32-bit range.
   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(32'sh7FFF_FFFF);
      lo = -PROD_W'(64'sh8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[VAL_W-1:0];
   endfunction

endpackage

/* src/tpe_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tpe_div.sv */
// Restoring divider that turns a duration into a tick count, one quotient bit per cycle.
`timescale 1ns / 1ps
module tpe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tpe_pkg::DUR_W-1:0]  dividend,
   input  logic [tpe_pkg::PER_W-1:0]  divisor,
   output logic                       done,
   output logic [tpe_pkg::DUR_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(tpe_pkg::DUR_W + 1);

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [tpe_pkg::PER_W:0]    rem_ff, rem_in;
   logic [tpe_pkg::DUR_W-1:0]  quo_ff, quo_in;
   logic [tpe_pkg::PER_W:0]    rem_sh;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff[tpe_pkg::PER_W-1:0], quo_ff[tpe_pkg::DUR_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = rem_sh - {1'b0, divisor};
            quo_in = {quo_ff[tpe_pkg::DUR_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[tpe_pkg::DUR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(tpe_pkg::DUR_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/timer_pool_with_expiry_core.sv */
// Top level of the timer pool: command sequencer around the slot record memory.
`timescale 1ns / 1ps
// A tick keeps busy high while each slot is read, then updated and written back; allocate with a
// signal checks each slot for a live timer on that signal, then waits on the 31-step divider; free,
// read, reset and time to expire pass dispatch, read, multiply and result; others end at dispatch.
// Each result transfer appears in the cycle after the busy cycle that made it.
// Throughput: one command at a time; busy is high until the command has finished.
// Reset clears all slots to free and the period register to one; results cannot be stalled.
module timer_pool_with_expiry_core #(
   parameter int SLOTS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tpe_pkg::req_type               req,
   output logic                           rsp_valid,
   output tpe_pkg::rsp_type               rsp,
   input  logic                           csr_wr_en,
   input  logic [tpe_pkg::PER_W-1:0]      csr_wr_data
);

   localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TICK_RD,
      S_TICK_UPD,
      S_TICK_END,
      S_CAN_RD,
      S_CAN_CHK,
      S_DIV,
      S_DIV_WAIT,
      S_ACC_RD,
      S_ACC_MUL,
      S_ACC_OUT
   } state_type;

   state_type                       state_ff, state_in;
   tpe_pkg::req_type                req_ff, req_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [IDX_W-1:0]                free_ff, free_in;
   logic                            pend_ff, pend_in;
   logic [IDX_W-1:0]                pend_slot_ff, pend_slot_in;
   logic [tpe_pkg::SIG_W-1:0]       pend_sig_ff, pend_sig_in;
   logic [SLOTS-1:0]                active_ff, active_in;
   logic [SLOTS-1:0]                signalled_ff, signalled_in;
   logic [CNT_W-1:0]                total_ff, total_in;
   logic [tpe_pkg::PER_W-1:0]       period_ff;
   logic signed [tpe_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tpe_pkg::rsp_type                rsp_ff, rsp_in;

   // Memory access and helper signals.
   logic                            ram_we, ram_re;
   logic [IDX_W-1:0]                ram_waddr, ram_raddr;
   tpe_pkg::slot_rec_type           ram_wdata, rec;
   logic [tpe_pkg::REC_W-1:0]       rd_raw;
   logic                            div_start, div_done;
   logic [tpe_pkg::DUR_W-1:0]       div_q;
   logic [tpe_pkg::PER_W-1:0]       period_eff;
   logic                            free_found;
   logic [IDX_W-1:0]                free_idx;
   logic                            slot_ok;
   logic [IDX_W-1:0]                slot_idx;
   logic [tpe_pkg::DUR_W-1:0]       el_next;
   logic signed [tpe_pkg::VAL_W-1:0] op_s;
   logic signed [tpe_pkg::VAL_W-1:0] val_s;

   // A period of zero is taken as one tick per millisecond.
   assign period_eff = (period_ff == '0) ? tpe_pkg::PER_W'(1) : period_ff;
   assign rec        = tpe_pkg::slot_rec_type'(rd_raw);
   assign slot_ok    = {1'b0, req_ff.slot_id} < (tpe_pkg::SLOT_W + 1)'(SLOTS);
   assign slot_idx   = req_ff.slot_id[IDX_W-1:0];
   assign el_next    = (rec.elapsed == tpe_pkg::ELAPSED_MAX) ? rec.elapsed
                                                             : rec.elapsed + 1'b1;

   // The lowest free slot wins an allocation.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   tpe_ram #(
      .WIDTH (tpe_pkg::REC_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd_raw)
   );

   tpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ff.duration_ms),
      .divisor  (period_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer: every command walks through the states below and then returns to idle.
   // Results are registered, so each transfer appears in the cycle after the state that made it.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      free_in      = free_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      pend_sig_in  = pend_sig_ff;
      active_in    = active_ff;
      signalled_in = signalled_ff;
      total_in     = total_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = idx_ff;
      ram_raddr    = idx_ff;
      ram_wdata    = rec;
      div_start    = 1'b0;
      op_s         = '0;
      val_s        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            state_in = S_IDLE;
            idx_in   = '0;
            pend_in  = 1'b0;
            unique case (req_ff.action) inside
               tpe_pkg::ACT_TICK: begin
                  state_in = S_TICK_RD;
               end
               tpe_pkg::ACT_ALLOC: begin
                  if (!free_found) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{tpe_pkg::STATUS_FULL, '0, '0, '0, 1'b1};
                  end else if (req_ff.has_signal) begin
                     free_in  = free_idx;
                     state_in = S_CAN_RD;
                  end else begin
                     // A stopwatch needs no target; only its elapsed count matters.
                     ram_we                  = 1'b1;
                     ram_waddr               = free_idx;
                     ram_wdata.sig           = req_ff.signal_id;
                     ram_wdata.target        = '0;
                     ram_wdata.elapsed       = '0;
                     active_in[free_idx]     = 1'b1;
                     signalled_in[free_idx]  = 1'b0;
                     total_in                = total_ff + 1'b1;
                     rsp_valid_in            = 1'b1;
                     rsp_in = '{tpe_pkg::STATUS_OK, tpe_pkg::SLOT_W'(free_idx), '0, '0, 1'b1};
                  end
               end
               tpe_pkg::ACT_FREE, tpe_pkg::ACT_READ, tpe_pkg::ACT_RESET,
               tpe_pkg::ACT_TTE: begin
                  if (slot_ok) begin
                     state_in = S_ACC_RD;
                  end else begin
                     // The null handle gives zero and changes nothing.
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{tpe_pkg::STATUS_OK, '0, '0, '0, 1'b1};
                  end
               end
               tpe_pkg::ACT_COUNT: begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{tpe_pkg::STATUS_OK, '0, tpe_pkg::VAL_W'(total_ff), '0, 1'b1};
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_TICK_RD: begin
            ram_re   = 1'b1;
            state_in = S_TICK_UPD;
         end

         S_TICK_UPD: begin
            if (active_ff[idx_ff]) begin
               ram_we            = 1'b1;
               ram_wdata.elapsed = el_next;
               if (signalled_ff[idx_ff] && el_next >= rec.target) begin
                  active_in[idx_ff] = 1'b0;
                  total_in          = total_ff - 1'b1;
                  // The previous notice is sent now that we know it was not the final one.
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{tpe_pkg::STATUS_EXPIRY, tpe_pkg::SLOT_W'(pend_slot_ff), '0,
                                pend_sig_ff, 1'b0};
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = idx_ff;
                  pend_sig_in  = rec.sig;
               end
            end
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_TICK_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TICK_RD;
            end
         end

         S_TICK_END: begin
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{tpe_pkg::STATUS_EXPIRY, tpe_pkg::SLOT_W'(pend_slot_ff), '0,
                          pend_sig_ff, 1'b1};
            end
            state_in = S_IDLE;
         end

         S_CAN_RD: begin
            ram_re   = 1'b1;
            state_in = S_CAN_CHK;
         end

         S_CAN_CHK: begin
            // Another live timer on the same signal is cancelled.
            if (idx_ff != free_ff && active_ff[idx_ff] && signalled_ff[idx_ff] &&
                rec.sig == req_ff.signal_id) begin
               active_in[idx_ff] = 1'b0;
               total_in          = total_ff - 1'b1;
            end
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_DIV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CAN_RD;
            end
         end

         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               ram_we                = 1'b1;
               ram_waddr             = free_ff;
               ram_wdata.sig         = req_ff.signal_id;
               ram_wdata.target      = div_q;
               ram_wdata.elapsed     = '0;
               active_in[free_ff]    = 1'b1;
               signalled_in[free_ff] = 1'b1;
               total_in              = total_ff + 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_in = '{tpe_pkg::STATUS_OK, tpe_pkg::SLOT_W'(free_ff), '0, '0, 1'b1};
               state_in              = S_IDLE;
            end
         end

         S_ACC_RD: begin
            ram_re    = 1'b1;
            ram_raddr = slot_idx;
            state_in  = S_ACC_MUL;
         end

         S_ACC_MUL: begin
            if (req_ff.action == tpe_pkg::ACT_TTE) begin
               op_s = $signed({1'b0, rec.target}) - $signed({1'b0, rec.elapsed});
            end else begin
               op_s = $signed({1'b0, rec.elapsed});
            end
            prod_in  = op_s * $signed({1'b0, period_eff});
            state_in = S_ACC_OUT;
         end

         S_ACC_OUT: begin
            val_s = tpe_pkg::sat32(prod_ff);
            if (req_ff.action == tpe_pkg::ACT_TTE && !signalled_ff[slot_idx]) begin
               val_s = -32'sd1;
            end
            rsp_valid_in = 1'b1;
            rsp_in       = '{tpe_pkg::STATUS_OK, '0, val_s, '0, 1'b1};
            if (req_ff.action == tpe_pkg::ACT_FREE && active_ff[slot_idx]) begin
               active_in[slot_idx] = 1'b0;
               total_in            = total_ff - 1'b1;
            end
            if (req_ff.action == tpe_pkg::ACT_RESET) begin
               ram_we            = 1'b1;
               ram_waddr         = slot_idx;
               ram_wdata.elapsed = '0;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         active_ff    <= '0;
         signalled_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         active_ff    <= active_in;
         signalled_ff <= signalled_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      req_ff       <= req_in;
      free_ff      <= free_in;
      pend_slot_ff <= pend_slot_in;
      pend_sig_ff  <= pend_sig_in;
      prod_ff      <= prod_in;
      rsp_ff       <= rsp_in;
   end

   // The period register is written whenever the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= tpe_pkg::PER_W'(1);
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTH
   // An accepted command always keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // The active count always matches the number of slots in use.
   a_total_match: assert property (@(posedge clock) disable iff (reset)
      total_ff == CNT_W'($countones(active_ff)))
      else $error("active count out of step with slot flags");

   // A result only ever follows a cycle in which a command was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without a command in progress");
`endif

endmodule
